[src/rotating_base85_codec_defines.svh]
// Assertion macros used by the checker file rbc_checker.
`ifndef ROTATING_BASE85_CODEC_DEFINES_SVH
`define ROTATING_BASE85_CODEC_DEFINES_SVH

// Check in the same cycle.
`define RBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check in the following cycle.
`define RBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rbc_pkg.sv]
package rbc_pkg;

	localparam int WORD_W     = 32;
	localparam int CHAR_W     = 7;
	localparam int DIG_W      = 7;
	localparam int BYTE_W     = 8;
	localparam int DIGITS     = 5;
	localparam int MOD85      = 85;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	// v / 85 == (v * RECIP) >> RECIP_SHIFT for every 32-bit v; the low
	// RECIP_SHIFT bits of the product, times 85, carry the remainder on top.
	localparam logic [WORD_W-1:0] RECIP = 32'd3233857729;
	localparam int RECIP_SHIFT = 38;
	localparam int PROD_W      = 2 * WORD_W;
	localparam int FRAC_PROD_W = RECIP_SHIFT + DIG_W;

	localparam int MQ_AW_DEF = 2;
	localparam int OQ_AW_DEF = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_STEP = 1'b1;

	typedef enum logic {
		MODE_ENC = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                  mode;
		logic [CFG_DATA_W-1:0]  rot_step;
	} cfg_t;

	// Work item between front and back: five digits for an encode, most significant at 0, or one decoded digit at 0.
	typedef struct packed {
		mode_t                        kind;
		logic [DIGITS-1:0][DIG_W-1:0] dig;
	} entry_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic [WORD_W-1:0] out_word;
		logic              last;
	} res_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIG_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 7'd10) begin
			c = d + 7'd48;
		end else if (d < 7'd36) begin
			c = d + 7'd87;
		end else if (d < 7'd62) begin
			c = d + 7'd29;
		end else begin
			unique case (d)
				7'd62:   c = 7'd46;
				7'd63:   c = 7'd45;
				7'd64:   c = 7'd58;
				7'd65:   c = 7'd43;
				7'd66:   c = 7'd61;
				7'd67:   c = 7'd94;
				7'd68:   c = 7'd33;
				7'd69:   c = 7'd47;
				7'd70:   c = 7'd42;
				7'd71:   c = 7'd63;
				7'd72:   c = 7'd38;
				7'd73:   c = 7'd60;
				7'd74:   c = 7'd62;
				7'd75:   c = 7'd40;
				7'd76:   c = 7'd41;
				7'd77:   c = 7'd91;
				7'd78:   c = 7'd93;
				7'd79:   c = 7'd123;
				7'd80:   c = 7'd125;
				7'd81:   c = 7'd64;
				7'd82:   c = 7'd37;
				7'd83:   c = 7'd36;
				7'd84:   c = 7'd35;
				default: c = 7'd0;
			endcase
		end
		return c;
	endfunction

	// Characters outside the alphabet map to digit zero.
	function automatic logic [DIG_W-1:0] char_to_digit(input logic [BYTE_W-1:0] ch);
		logic [DIG_W-1:0] d;
		if (ch >= 8'd48 && ch <= 8'd57) begin
			d = DIG_W'(ch - 8'd48);
		end else if (ch >= 8'd97 && ch <= 8'd122) begin
			d = DIG_W'(ch - 8'd87);
		end else if (ch >= 8'd65 && ch <= 8'd90) begin
			d = DIG_W'(ch - 8'd29);
		end else begin
			unique case (ch)
				8'd46:   d = 7'd62;
				8'd45:   d = 7'd63;
				8'd58:   d = 7'd64;
				8'd43:   d = 7'd65;
				8'd61:   d = 7'd66;
				8'd94:   d = 7'd67;
				8'd33:   d = 7'd68;
				8'd47:   d = 7'd69;
				8'd42:   d = 7'd70;
				8'd63:   d = 7'd71;
				8'd38:   d = 7'd72;
				8'd60:   d = 7'd73;
				8'd62:   d = 7'd74;
				8'd40:   d = 7'd75;
				8'd41:   d = 7'd76;
				8'd91:   d = 7'd77;
				8'd93:   d = 7'd78;
				8'd123:  d = 7'd79;
				8'd125:  d = 7'd80;
				8'd64:   d = 7'd81;
				8'd37:   d = 7'd82;
				8'd36:   d = 7'd83;
				8'd35:   d = 7'd84;
				default: d = 7'd0;
			endcase
		end
		return d;
	endfunction

endpackage

[src/rbc_fifo.sv]
module rbc_fifo #(
	parameter int W  = 8,
	parameter int AW = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int DEPTH = 2 ** AW;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[src/rbc_front.sv]
module rbc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rbc_pkg::mode_t                   mode,
	input  logic                             push,
	output logic                             full,
	input  logic [rbc_pkg::WORD_W-1:0]       data_in,
	output logic                             mq_push,
	output rbc_pkg::entry_t                  mq_wdata,
	input  logic                             mq_full
);

	localparam int FRAC_W = rbc_pkg::RECIP_SHIFT;
	localparam logic [2:0] LAST_STEP = 3'(rbc_pkg::DIGITS - 1);

	// Digit extraction: one multiply per cycle while not stalled, least significant digit first.
	logic                            busy_q;
	logic [2:0]                      cnt_q;
	logic [rbc_pkg::WORD_W-1:0]      v_q;
	logic [rbc_pkg::PROD_W-1:0]      prod;

	logic                            s1_vld_q;
	rbc_pkg::mode_t                  s1_kind_s1;
	logic [FRAC_W-1:0]               s1_frac_s1;
	logic [2:0]                      s1_idx_s1;
	logic [rbc_pkg::BYTE_W-1:0]      s1_char_s1;

	logic [4:1][rbc_pkg::DIG_W-1:0]  digits_q;
	logic [rbc_pkg::FRAC_PROD_W-1:0] fprod;
	logic [rbc_pkg::DIG_W-1:0]       frac_digit;

	logic push_need;
	logic stall;
	logic acc;
	logic enc_acc;
	logic dec_acc;

	assign prod       = rbc_pkg::PROD_W'(v_q) * rbc_pkg::PROD_W'(rbc_pkg::RECIP);
	assign fprod      = rbc_pkg::FRAC_PROD_W'(s1_frac_s1)
		* rbc_pkg::FRAC_PROD_W'(rbc_pkg::MOD85);
	assign frac_digit = fprod[rbc_pkg::FRAC_PROD_W-1:FRAC_W];

	assign push_need = s1_vld_q && (s1_kind_s1 == rbc_pkg::MODE_DEC || s1_idx_s1 == 3'd0);
	assign stall     = push_need && mq_full;

	// A new word may enter on the edge of the last multiply of the previous one.
	assign full    = stall || (busy_q && !(cnt_q == LAST_STEP && mode == rbc_pkg::MODE_ENC));
	assign acc     = push && !full;
	assign enc_acc = acc && mode == rbc_pkg::MODE_ENC;
	assign dec_acc = acc && mode == rbc_pkg::MODE_DEC;

	always_comb begin
		mq_push  = push_need && !mq_full;
		mq_wdata = '0;
		mq_wdata.kind = s1_kind_s1;
		if (s1_kind_s1 == rbc_pkg::MODE_DEC) begin
			mq_wdata.dig[0] = rbc_pkg::char_to_digit(s1_char_s1);
		end else begin
			mq_wdata.dig[0] = frac_digit;
			mq_wdata.dig[1] = digits_q[1];
			mq_wdata.dig[2] = digits_q[2];
			mq_wdata.dig[3] = digits_q[3];
			mq_wdata.dig[4] = digits_q[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			s1_vld_q <= 1'b0;
		end else if (!stall) begin
			s1_vld_q <= busy_q || dec_acc;
			if (busy_q) begin
				cnt_q  <= cnt_q + 1'b1;
				busy_q <= (cnt_q != LAST_STEP);
			end
			if (enc_acc) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			if (busy_q) begin
				v_q        <= rbc_pkg::WORD_W'(prod[rbc_pkg::PROD_W-1:FRAC_W]);
				s1_frac_s1 <= prod[FRAC_W-1:0];
				s1_idx_s1  <= LAST_STEP - cnt_q;
				s1_kind_s1 <= rbc_pkg::MODE_ENC;
			end
			if (dec_acc) begin
				s1_kind_s1 <= rbc_pkg::MODE_DEC;
				s1_char_s1 <= data_in[rbc_pkg::BYTE_W-1:0];
			end
			if (enc_acc) begin
				v_q <= data_in;
			end
			if (s1_vld_q && s1_kind_s1 == rbc_pkg::MODE_ENC && s1_idx_s1 != 3'd0) begin
				digits_q[s1_idx_s1] <= frac_digit;
			end
		end
	end

endmodule

[src/rbc_back.sv]
module rbc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rbc_pkg::cfg_t   cfg,
	input  rbc_pkg::entry_t head,
	input  logic            mq_empty,
	output logic            mq_pop,
	output logic            oq_push,
	output rbc_pkg::res_t   oq_wdata,
	input  logic            oq_full
);

	localparam logic [2:0] LAST_DIGIT = 3'(rbc_pkg::DIGITS - 1);
	localparam logic [7:0] M85_8 = 8'(rbc_pkg::MOD85);
	localparam logic [6:0] M85_7 = 7'(rbc_pkg::MOD85);

	logic [rbc_pkg::DIG_W-1:0]  off_q;
	logic [2:0]                 cnt_q;
	logic [2:0]                 dcnt_q;
	logic [rbc_pkg::WORD_W-1:0] acc_q;

	logic                       go;
	logic                       is_enc;
	logic [6:0]                 step_eff;
	logic [7:0]                 rsum;
	logic [6:0]                 off_nx;
	logic [7:0]                 esum;
	logic [6:0]                 nidx;
	logic [7:0]                 dsum;
	logic [6:0]                 dval;
	logic [rbc_pkg::WORD_W-1:0] acc_nx;

	assign go     = !mq_empty && !oq_full;
	assign is_enc = (head.kind == rbc_pkg::MODE_ENC);

	always_comb begin
		step_eff = (cfg.rot_step >= M85_7) ? cfg.rot_step - M85_7 : cfg.rot_step;
		rsum     = {1'b0, off_q} + {1'b0, step_eff};
		off_nx   = (rsum >= M85_8) ? 7'(rsum - M85_8) : 7'(rsum);

		// Encode: lower the digit by the running offset.
		esum = {1'b0, head.dig[cnt_q]} + M85_8 - {1'b0, off_q};
		nidx = (esum >= M85_8) ? 7'(esum - M85_8) : 7'(esum);

		// Decode: add the offset back, then fold into the word.
		dsum   = {1'b0, head.dig[0]} + {1'b0, off_q};
		dval   = (dsum >= M85_8) ? 7'(dsum - M85_8) : 7'(dsum);
		acc_nx = acc_q * rbc_pkg::WORD_W'(rbc_pkg::MOD85) + rbc_pkg::WORD_W'(dval);

		oq_push  = go && (is_enc || dcnt_q == LAST_DIGIT);
		mq_pop   = go && (!is_enc || cnt_q == LAST_DIGIT);
		oq_wdata = '0;
		if (is_enc) begin
			oq_wdata.out_char = rbc_pkg::digit_to_char(nidx);
			oq_wdata.last     = (cnt_q == LAST_DIGIT);
		end else begin
			oq_wdata.out_word = acc_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			cnt_q  <= '0;
			dcnt_q <= '0;
			acc_q  <= '0;
		end else if (go) begin
			off_q <= off_nx;
			if (is_enc) begin
				cnt_q <= (cnt_q == LAST_DIGIT) ? 3'd0 : cnt_q + 1'b1;
			end else if (dcnt_q == LAST_DIGIT) begin
				dcnt_q <= '0;
				acc_q  <= '0;
			end else begin
				dcnt_q <= dcnt_q + 1'b1;
				acc_q  <= acc_nx;
			end
		end
	end

endmodule

[src/rotating_base85_codec.sv]
// Z85 codec with a per-symbol rotation. Write mode (register 0) and rot_step
// (register 1) while idle. In encode mode each pushed 32-bit word yields five
// characters, most significant digit first, with last set on the fifth; the
// front end takes a new word only as the shared divide-by-85 multiplier
// finishes the last one (one digit per cycle while not stalled), and the back
// end emits one character per cycle while neither queue holds it off. In
// decode mode one character is taken per cycle while the front end is not
// stalled, and every fifth one yields a word. A word's characters reach the
// result ports through the s1 registers, the mid queue and the output queue,
// as does a decoded word after its fifth character. The rotation offset and
// a partly gathered word survive mode changes and are cleared only by reset.
module rotating_base85_codec #(
	parameter int MQ_AW = rbc_pkg::MQ_AW_DEF,
	parameter int OQ_AW = rbc_pkg::OQ_AW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [rbc_pkg::WORD_W-1:0]       data_in,
	output logic                             empty,
	input  logic                             pop,
	output logic [rbc_pkg::CHAR_W-1:0]       out_char,
	output logic [rbc_pkg::WORD_W-1:0]       out_word,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	rbc_pkg::cfg_t   cfg_q;
	logic            mq_push;
	rbc_pkg::entry_t mq_wdata;
	logic            mq_full;
	logic            mq_pop;
	rbc_pkg::entry_t mq_head;
	logic            mq_empty;
	logic            oq_push;
	rbc_pkg::res_t   oq_wdata;
	logic            oq_full;
	logic            oq_pop;
	rbc_pkg::res_t   oq_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= rbc_pkg::MODE_ENC;
			cfg_q.rot_step <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rbc_pkg::REG_MODE:     cfg_q.mode     <= rbc_pkg::mode_t'(cfg_data[0]);
				rbc_pkg::REG_ROT_STEP: cfg_q.rot_step <= cfg_data;
				default: ;
			endcase
		end
	end

	rbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (cfg_q.mode),
		.push     (push),
		.full     (full),
		.data_in  (data_in),
		.mq_push  (mq_push),
		.mq_wdata (mq_wdata),
		.mq_full  (mq_full)
	);

	rbc_fifo #(
		.W  ($bits(rbc_pkg::entry_t)),
		.AW (MQ_AW)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mq_push),
		.wdata  (mq_wdata),
		.full   (mq_full),
		.rd_en  (mq_pop),
		.rdata  (mq_head),
		.empty  (mq_empty)
	);

	rbc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (mq_head),
		.mq_empty (mq_empty),
		.mq_pop   (mq_pop),
		.oq_push  (oq_push),
		.oq_wdata (oq_wdata),
		.oq_full  (oq_full)
	);

	assign oq_pop = pop && !empty;

	rbc_fifo #(
		.W  ($bits(rbc_pkg::res_t)),
		.AW (OQ_AW)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (oq_push),
		.wdata  (oq_wdata),
		.full   (oq_full),
		.rd_en  (oq_pop),
		.rdata  (oq_head),
		.empty  (empty)
	);

	assign out_char = oq_head.out_char;
	assign out_word = oq_head.out_word;
	assign last     = oq_head.last;

endmodule

[src/rbc_checker.sv]
`include "rotating_base85_codec_defines.svh"

module rbc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        empty,
	input logic                        pop,
	input logic [rbc_pkg::CHAR_W-1:0]  out_char,
	input logic [rbc_pkg::WORD_W-1:0]  out_word,
	input logic                        last,
	input logic                        cfg_valid,
	input logic                        cfg_ready
);

	// A waiting result stays put until taken.
	`RBC_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(out_char) && $stable(out_word) && $stable(last), "result changed while waiting")

	// A result carries either a character or a word, never both.
	`RBC_ASSERT_NOW(a_char_or_word, !empty, out_char == '0 || out_word == '0, "result has both a character and a word")

	// The closing character of a group is a real character and has no word.
	`RBC_ASSERT_NOW(a_last_is_char, !empty && last, out_char != '0 && out_word == '0, "last set on a result that is not a character")

	// Register writes are never held off.
	`RBC_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind rotating_base85_codec rbc_checker u_rbc_checker (.*);

[dv/rotating_base85_codec_checker.sv]
module rotating_base85_codec_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic                             full,
	input  logic [rbc_pkg::WORD_W-1:0]       data_in,
	input  logic                             empty,
	input  logic                             pop,
	input  logic [rbc_pkg::CHAR_W-1:0]       out_char,
	input  logic [rbc_pkg::WORD_W-1:0]       out_word,
	input  logic                             last,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [rbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                               mismatch_total,
	output int                               words_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	// Digit k sits in byte (84 - k), first symbol in the top byte.
	localparam logic [8*rbc_pkg::MOD85-1:0] Z85_SYMBOLS =
		"0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

	rbc_pkg::mode_t                 cur_mode;
	logic [rbc_pkg::CFG_DATA_W-1:0] cur_step;
	int unsigned                    rotation;
	int unsigned                    gathered;
	logic [rbc_pkg::WORD_W-1:0]     partial_word;
	rbc_pkg::res_t                  owed_q[$];
	int                             mismatch_count = 0;
	int                             owed_count = 0;

	assign mismatch_total = mismatch_count;
	assign words_owed     = owed_count;

	function automatic logic [rbc_pkg::CHAR_W-1:0] symbol_of(input int unsigned n);
		return Z85_SYMBOLS[8*(rbc_pkg::MOD85-1-n) +: rbc_pkg::CHAR_W];
	endfunction

	function automatic int unsigned digit_of(input logic [rbc_pkg::BYTE_W-1:0] ch);
		int unsigned k;
		for (k = 0; k < rbc_pkg::MOD85; k++) begin
			if (Z85_SYMBOLS[8*(rbc_pkg::MOD85-1-k) +: rbc_pkg::BYTE_W] == ch) begin
				return k;
			end
		end
		return 0;
	endfunction

	function automatic void advance_rotation();
		rotation = (rotation + cur_step % rbc_pkg::MOD85) % rbc_pkg::MOD85;
	endfunction

	function automatic void step_codec(input logic [rbc_pkg::WORD_W-1:0] data);
		int unsigned   digits [rbc_pkg::DIGITS];
		int unsigned   rest;
		int unsigned   n;
		int unsigned   d;
		rbc_pkg::res_t r;
		if (cur_mode == rbc_pkg::MODE_ENC) begin
			rest = data;
			for (int k = rbc_pkg::DIGITS - 1; k >= 0; k--) begin
				digits[k] = rest % rbc_pkg::MOD85;
				rest = rest / rbc_pkg::MOD85;
			end
			for (int k = 0; k < rbc_pkg::DIGITS; k++) begin
				n = (digits[k] + rbc_pkg::MOD85 - rotation) % rbc_pkg::MOD85;
				advance_rotation();
				r.out_char = symbol_of(n);
				r.out_word = '0;
				r.last     = (k == rbc_pkg::DIGITS - 1);
				owed_q = {owed_q, r};
			end
		end else begin
			d = (digit_of(data[rbc_pkg::BYTE_W-1:0]) + rotation) % rbc_pkg::MOD85;
			advance_rotation();
			partial_word = partial_word * 32'd85 + rbc_pkg::WORD_W'(d);
			gathered++;
			if (gathered == rbc_pkg::DIGITS) begin
				r.out_char = '0;
				r.out_word = partial_word;
				r.last     = 1'b0;
				owed_q = {owed_q, r};
				partial_word = '0;
				gathered = 0;
			end
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_result();
		rbc_pkg::res_t want;
		if (owed_q.size() == 0) begin
			report_mismatch($sformatf("unrequested word: char %0h word %0h last %0b",
				out_char, out_word, last));
			return;
		end
		want = owed_q.pop_front();
		if (out_char !== want.out_char) begin
			report_mismatch($sformatf("out_char %0h, predicted %0h", out_char, want.out_char));
		end
		if (out_word !== want.out_word) begin
			report_mismatch($sformatf("out_word %0h, predicted %0h", out_word, want.out_word));
		end
		if (last !== want.last) begin
			report_mismatch($sformatf("last %0b, predicted %0b", last, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = rbc_pkg::MODE_ENC;
			cur_step = '0;
			rotation = 0;
			gathered = 0;
			partial_word = '0;
			owed_q.delete();
		end else begin
			if (pop && !empty) begin
				check_result();
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rbc_pkg::REG_MODE:     cur_mode = rbc_pkg::mode_t'(cfg_data[0]);
					rbc_pkg::REG_ROT_STEP: cur_step = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) begin
				step_codec(data_in);
			end
		end
		owed_count = owed_q.size();
	end

endmodule

[dv/tb_rotating_base85_codec.sv]
module tb_rotating_base85_codec;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int RX_HOLD_CYCLES = 90;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           push = 1'b0;
	logic                           full;
	logic [rbc_pkg::WORD_W-1:0]     data_in = '0;
	logic                           empty;
	logic                           pop = 1'b0;
	logic [rbc_pkg::CHAR_W-1:0]     out_char;
	logic [rbc_pkg::WORD_W-1:0]     out_word;
	logic                           last;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [rbc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int                             mismatch_total;
	int                             words_owed;
	int                             tx_idle = 0;
	int                             rx_idle = 0;
	logic                           rx_hold = 1'b0;
	int                             cycle_count = 0;

	always #1 clk = ~clk;

	rotating_base85_codec DUT (.*);

	rotating_base85_codec_checker u_checker (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("rotating_base85_codec: mismatch");
			$finish;
		end
	end

	initial begin : receiver
		int held;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				pop = 1'b0;
				for (held = 0; held < RX_HOLD_CYCLES; held++) begin
					@(negedge clk);
				end
				rx_hold = 1'b0;
			end
			pop = ($urandom_range(99) >= rx_idle);
		end
	end

	// Drop push, wait for every owed word, then let the pipeline empty.
	task automatic settle();
		push = 1'b0;
		wait (words_owed == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after its last write.
	task automatic write_reg(input logic [rbc_pkg::CFG_IDX_W-1:0] idx,
			input logic [rbc_pkg::CFG_DATA_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_mode(input rbc_pkg::mode_t m);
		settle();
		write_reg(rbc_pkg::REG_MODE, {(rbc_pkg::CFG_DATA_W-1)'($urandom), m});
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input rbc_pkg::mode_t m,
			input logic [rbc_pkg::CFG_DATA_W-1:0] step);
		settle();
		write_reg(rbc_pkg::REG_ROT_STEP, step);
		write_reg(rbc_pkg::REG_MODE, {(rbc_pkg::CFG_DATA_W-1)'($urandom), m});
		cfg_valid = 1'b0;
	endtask

	task automatic send_item(input logic [rbc_pkg::WORD_W-1:0] d);
		while ($urandom_range(99) < tx_idle) begin
			push = 1'b0;
			@(negedge clk);
		end
		push    = 1'b1;
		data_in = d;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [rbc_pkg::WORD_W-1:0] random_char(input bit noisy);
		logic [rbc_pkg::WORD_W-rbc_pkg::BYTE_W-1:0] upper;
		logic [rbc_pkg::BYTE_W-1:0]                 ch;
		upper = ($urandom_range(3) == 0) ?
			(rbc_pkg::WORD_W-rbc_pkg::BYTE_W)'($urandom) : '0;
		ch = noisy ? rbc_pkg::BYTE_W'($urandom) :
			{1'b0, rbc_pkg::digit_to_char(rbc_pkg::DIG_W'($urandom_range(84)))};
		return {upper, ch};
	endfunction

	function automatic logic [rbc_pkg::CFG_DATA_W-1:0] random_step();
		case ($urandom_range(7))
			0: return 7'd0;
			1: return 7'd84;
			2: return 7'd85;
			3: return 7'd127;
			default: return rbc_pkg::CFG_DATA_W'($urandom);
		endcase
	endfunction

	task automatic run_segment(input rbc_pkg::mode_t m, input int n);
		int  sent;
		int  len;
		bit  noisy;
		sent = 0;
		if (m == rbc_pkg::MODE_ENC) begin
			repeat (n) begin
				case ($urandom_range(7))
					0: send_item('0);
					1: send_item('1);
					default: send_item($urandom);
				endcase
			end
		end else begin
			// Mostly clean five-symbol groups; some runs of stray bytes break the framing.
			while (sent < n) begin
				noisy = ($urandom_range(9) < 2);
				len = noisy ? $urandom_range(1, 7) : rbc_pkg::DIGITS;
				repeat (len) send_item(random_char(noisy));
				sent += len;
			end
		end
	endtask

	initial begin : stimulus
		int             r;
		int             s;
		rbc_pkg::mode_t m;
		tx_idle = 19;
		rx_idle = 52;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// All top digits: the group overflows 32 bits and wraps.
		configure(rbc_pkg::MODE_DEC, 7'd0);
		repeat (rbc_pkg::DIGITS) send_item(32'h0000_0023);
		// Bytes outside the alphabet, and upper bits set over a valid symbol.
		send_item(32'h0000_0080);
		send_item(32'h0000_00FF);
		send_item(32'h0000_0020);
		send_item(32'hFFFF_FF41);
		send_item(32'h0000_007E);

		configure(rbc_pkg::MODE_ENC, 7'd0);
		send_item(32'h0000_0000);
		send_item(32'hFFFF_FFFF);
		send_item(32'h0000_0001);
		configure(rbc_pkg::MODE_ENC, 7'd84);
		send_item(32'hFFFF_FFFF);
		send_item(32'h0000_0055);

		// Mode switch in the middle of a decode group.
		configure(rbc_pkg::MODE_DEC, 7'd127);
		send_item(32'h0000_007A);
		send_item(32'h0000_002A);
		set_mode(rbc_pkg::MODE_ENC);
		send_item(32'hDEAD_BEEF);
		set_mode(rbc_pkg::MODE_DEC);
		send_item(32'h0000_002E);
		send_item(32'h0000_0040);
		send_item(32'hAAAA_AA25);

		for (r = 0; r < 3; r++) begin
			tx_idle = (r == 0) ? 19 : (r == 1) ? 52 : 0;
			rx_idle = (r == 0) ? 52 : (r == 1) ? 19 : 0;
			for (s = 0; s < 6; s++) begin
				m = (r == 0 && s == 1) ? rbc_pkg::MODE_ENC :
					rbc_pkg::mode_t'($urandom_range(1));
				configure(m, random_step());
				if (r == 0 && s == 1) begin
					// stall the output so the block backs up into its input
					rx_hold = 1'b1;
				end
				if (r == 1 && s == 2) begin
					run_segment(m, 10);
					settle();
					run_segment(m, 10);
				end else begin
					run_segment(m, (m == rbc_pkg::MODE_ENC) ? 12 : 26);
				end
			end
		end

		settle();
		if (mismatch_total == 0 && words_owed == 0) begin
			$display("rotating_base85_codec: match");
		end else begin
			$display("rotating_base85_codec: mismatch");
		end
		$finish;
	end

endmodule
